### hdl/rgb_hue_color_classifier_assert.svh
// ----------------------------------------------------------------------------
// RGB hue color classifier assertion macros
// Shorthand for clocked concurrent assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_HUE_COLOR_CLASSIFIER_ASSERT_SVH
`define RGB_HUE_COLOR_CLASSIFIER_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define RHCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define RHCC_ASSERT(lbl, prop, msg) `RHCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/rhcc_pkg.sv
// ----------------------------------------------------------------------------
// RGB hue color classifier package
// Shared types, register indexes, color codes and reset values.
// ----------------------------------------------------------------------------
package rhcc_pkg;

  localparam int HUE_BITS_DEF    = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int DATA_W          = 16;  // width of every raw count field
  localparam int THR_W           = 10;  // width of a hue threshold register
  localparam int HUE_OUT_W       = 10;  // width of the reported hue field
  localparam int CODE_W          = 3;
  localparam int IDX_W           = 3;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [DATA_W-1:0] DARK_RESET = 16'd65000;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_WHITE_OFFSET = 3'd0;
  localparam logic [IDX_W-1:0] CFG_BLACK_OFFSET = 3'd1;
  localparam logic [IDX_W-1:0] CFG_RED_HIGH_THR = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MAGENTA_THR  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_BLUE_THR     = 3'd4;
  localparam logic [IDX_W-1:0] CFG_CYAN_THR     = 3'd5;
  localparam logic [IDX_W-1:0] CFG_GREEN_THR    = 3'd6;
  localparam logic [IDX_W-1:0] CFG_YELLOW_THR   = 3'd7;

  typedef enum logic [CODE_W-1:0] {
    CODE_WHITE   = 3'd0,
    CODE_BLACK   = 3'd1,
    CODE_RED     = 3'd2,
    CODE_MAGENTA = 3'd3,
    CODE_BLUE    = 3'd4,
    CODE_CYAN    = 3'd5,
    CODE_GREEN   = 3'd6,
    CODE_YELLOW  = 3'd7
  } color_e;

  // Brightness verdict made when the sample is accepted.
  typedef enum logic [1:0] {
    KIND_HUE   = 2'd0,
    KIND_WHITE = 2'd1,
    KIND_BLACK = 2'd2
  } kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] white_offset;
    logic [DATA_W-1:0] black_offset;
    logic [THR_W-1:0]  red_high_thr;
    logic [THR_W-1:0]  magenta_thr;
    logic [THR_W-1:0]  blue_thr;
    logic [THR_W-1:0]  cyan_thr;
    logic [THR_W-1:0]  green_thr;
    logic [THR_W-1:0]  yellow_thr;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    white_offset: 16'd100,
    black_offset: 16'd100,
    red_high_thr: 10'd922,
    magenta_thr:  10'd768,
    blue_thr:     10'd563,
    cyan_thr:     10'd461,
    green_thr:    10'd205,
    yellow_thr:   10'd102
  };

endpackage

### hdl/rhcc_front.sv
// ----------------------------------------------------------------------------
// RGB hue color classifier front end
// Tracks the clear-channel extremes, makes the white/black verdict and
// prepares the hue dividend and divisor for each accepted sample.
// ----------------------------------------------------------------------------
module rhcc_front import rhcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int D6_W = SAMPLE_BITS + 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              push_i,
  input  logic [DATA_W-1:0] red_i,
  input  logic [DATA_W-1:0] green_i,
  input  logic [DATA_W-1:0] blue_i,
  input  logic [DATA_W-1:0] clear_i,
  output kind_e             kind_o,
  output logic [D6_W-1:0]   num_o,
  output logic [D6_W-1:0]   div_o
);

  localparam logic [DATA_W:0] SAMPLE_MAX = (DATA_W+1)'((1 << SAMPLE_BITS) - 1);

  logic [DATA_W-1:0]      dark_q, dark_d;
  logic [DATA_W-1:0]      bright_q, bright_d;
  logic [SAMPLE_BITS-1:0] r, g, b, c;
  logic [DATA_W-1:0]      c_ext;
  logic [DATA_W-1:0]      white_thr;
  logic [DATA_W:0]        black_sum, black_thr;
  logic                   is_white, is_black;
  logic                   blue_max, green_max;
  logic [SAMPLE_BITS-1:0] mx, mn, d;
  logic [D6_W-1:0]        r_x, g_x, b_x, d_x, d6;

  assign r     = red_i[SAMPLE_BITS-1:0];
  assign g     = green_i[SAMPLE_BITS-1:0];
  assign b     = blue_i[SAMPLE_BITS-1:0];
  assign c     = clear_i[SAMPLE_BITS-1:0];
  assign c_ext = DATA_W'(c);

  // Extremes include the current sample before the brightness verdict.
  assign dark_d   = (c_ext < dark_q) ? c_ext : dark_q;
  assign bright_d = (c_ext > bright_q) ? c_ext : bright_q;

  assign white_thr = (bright_d > cfg_i.white_offset) ? bright_d - cfg_i.white_offset : '0;
  assign black_sum = {1'b0, dark_d} + {1'b0, cfg_i.black_offset};
  assign black_thr = (black_sum > SAMPLE_MAX) ? SAMPLE_MAX : black_sum;
  assign is_white  = c_ext > white_thr;
  assign is_black  = {1'b0, c_ext} < black_thr;

  always_comb begin
    if (is_white) begin
      kind_o = KIND_WHITE;
    end else if (is_black) begin
      kind_o = KIND_BLACK;
    end else begin
      kind_o = KIND_HUE;
    end
  end

  // On a tie for the maximum, blue wins over green and green over red.
  assign blue_max  = (b >= r) && (b >= g);
  assign green_max = !blue_max && (g >= r);

  always_comb begin
    if (blue_max) begin
      mx = b;
    end else if (green_max) begin
      mx = g;
    end else begin
      mx = r;
    end
    mn = r;
    if (g < mn) begin
      mn = g;
    end
    if (b < mn) begin
      mn = b;
    end
  end

  assign d   = mx - mn;
  assign r_x = D6_W'(r);
  assign g_x = D6_W'(g);
  assign b_x = D6_W'(b);
  assign d_x = D6_W'(d);
  assign d6  = (d_x << 2) + (d_x << 1);

  // A gray sample divides zero by one so the divider yields a zero hue.
  always_comb begin
    div_o = d6;
    if (d == '0) begin
      num_o = '0;
      div_o = D6_W'(1);
    end else if (blue_max) begin
      num_o = (d_x << 2) + r_x - g_x;
    end else if (green_max) begin
      num_o = (d_x << 1) + b_x - r_x;
    end else if (g >= b) begin
      num_o = g_x - b_x;
    end else begin
      num_o = d6 - (b_x - g_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q   <= DARK_RESET;
      bright_q <= '0;
    end else if (push_i) begin
      dark_q   <= dark_d;
      bright_q <= bright_d;
    end
  end

endmodule

### hdl/rhcc_fifo.sv
// ----------------------------------------------------------------------------
// RGB hue color classifier work queue
// Small register queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module rhcc_fifo import rhcc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/rhcc_back.sv
// ----------------------------------------------------------------------------
// RGB hue color classifier back end
// Restoring divider for the hue, threshold compare and output register.
// ----------------------------------------------------------------------------
module rhcc_back import rhcc_pkg::*; #(
  parameter int HUE_BITS    = HUE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int D6_W = SAMPLE_BITS + 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 avail_i,
  input  kind_e                kind_i,
  input  logic [D6_W-1:0]      num_i,
  input  logic [D6_W-1:0]      div_i,
  output logic                 pop_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output color_e               color_o,
  output logic [HUE_OUT_W-1:0] hue_o
);

  localparam int CNT_W = (HUE_BITS > 1) ? $clog2(HUE_BITS) : 1;
  localparam int CMP_W = (HUE_BITS > THR_W) ? HUE_BITS : THR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [D6_W-1:0]     rem_q, rem_d;
  logic [D6_W-1:0]     div_q, div_d;
  logic [HUE_BITS-1:0] quot_q, quot_d;
  kind_e               kind_q, kind_d;
  logic                out_vld_q, out_vld_d;
  color_e              color_q, color_d;
  logic [HUE_OUT_W-1:0] hue_q, hue_d;
  logic [D6_W:0]       rem_shift;
  logic                fits;
  logic                load_out;
  logic [CMP_W-1:0]    hue_cmp;
  color_e              hue_color;

  assign rem_shift = {rem_q, 1'b0};
  assign fits      = rem_shift >= {1'b0, div_q};
  assign hue_cmp   = CMP_W'(quot_q);
  assign load_out  = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);
  assign pop_o     = (state_q == ST_IDLE) && avail_i;
  assign busy_o    = state_q != ST_IDLE;

  // First matching threshold wins; thresholds need not be ordered.
  always_comb begin
    if (hue_cmp > CMP_W'(cfg_i.red_high_thr)) begin
      hue_color = CODE_RED;
    end else if (hue_cmp > CMP_W'(cfg_i.magenta_thr)) begin
      hue_color = CODE_MAGENTA;
    end else if (hue_cmp > CMP_W'(cfg_i.blue_thr)) begin
      hue_color = CODE_BLUE;
    end else if (hue_cmp > CMP_W'(cfg_i.cyan_thr)) begin
      hue_color = CODE_CYAN;
    end else if (hue_cmp > CMP_W'(cfg_i.green_thr)) begin
      hue_color = CODE_GREEN;
    end else if (hue_cmp > CMP_W'(cfg_i.yellow_thr)) begin
      hue_color = CODE_YELLOW;
    end else begin
      hue_color = CODE_RED;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    div_d     = div_q;
    quot_d    = quot_q;
    kind_d    = kind_q;
    out_vld_d = out_vld_q;
    color_d   = color_q;
    hue_d     = hue_q;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          rem_d   = num_i;
          div_d   = div_i;
          kind_d  = kind_i;
          quot_d  = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; the remainder stays below the divisor.
        rem_d  = fits ? D6_W'(rem_shift - {1'b0, div_q}) : D6_W'(rem_shift);
        quot_d = {quot_q[HUE_BITS-2:0], fits};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HUE_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          hue_d     = HUE_OUT_W'(quot_q);
          case (kind_q)
            KIND_WHITE: color_d = CODE_WHITE;
            KIND_BLACK: color_d = CODE_BLACK;
            default:    color_d = hue_color;
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    div_q   <= div_d;
    quot_q  <= quot_d;
    kind_q  <= kind_d;
    color_q <= color_d;
    hue_q   <= hue_d;
  end

  assign out_valid_o = out_vld_q;
  assign color_o     = color_q;
  assign hue_o       = hue_q;

endmodule

### hdl/rgb_hue_color_classifier.sv
// The shared restoring divider resolves one hue bit per cycle and takes the next
// sample from the queue only after it has loaded the result of the last one.
// A two-entry queue lets the input side take samples while the divider works.
// Reset (asynchronous, active low) loads the register defaults, sets the darkest
// clear value to 65000 and the brightest to zero, and empties the queue.
// ----------------------------------------------------------------------------
// RGB hue color classifier
// Classifies raw red, green, blue and clear sensor counts into one of eight
// color codes and reports the hue as a fraction of a turn.
// ----------------------------------------------------------------------------
`include "rgb_hue_color_classifier_assert.svh"

module rgb_hue_color_classifier import rhcc_pkg::*; #(
  parameter int HUE_BITS    = HUE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  // Sample input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [63:0]       s_axis_tdata_i,  // red_count, green_count, blue_count, clear_count
  // Result output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o   // color_code, hue_value, zero padding
);

  localparam int D6_W    = SAMPLE_BITS + 3;
  localparam int ENTRY_W = 2 + 2 * D6_W;

  cfg_t                 cfg_q;
  logic                 push, pop;
  logic                 fifo_full, fifo_empty;
  logic                 back_busy;
  kind_e                front_kind;
  logic [D6_W-1:0]      front_num, front_div;
  logic [ENTRY_W-1:0]   push_entry, head_entry;
  color_e               color;
  logic [HUE_OUT_W-1:0] hue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WHITE_OFFSET: cfg_q.white_offset <= cfg_data_i;
        CFG_BLACK_OFFSET: cfg_q.black_offset <= cfg_data_i;
        CFG_RED_HIGH_THR: cfg_q.red_high_thr <= cfg_data_i[THR_W-1:0];
        CFG_MAGENTA_THR:  cfg_q.magenta_thr  <= cfg_data_i[THR_W-1:0];
        CFG_BLUE_THR:     cfg_q.blue_thr     <= cfg_data_i[THR_W-1:0];
        CFG_CYAN_THR:     cfg_q.cyan_thr     <= cfg_data_i[THR_W-1:0];
        CFG_GREEN_THR:    cfg_q.green_thr    <= cfg_data_i[THR_W-1:0];
        CFG_YELLOW_THR:   cfg_q.yellow_thr   <= cfg_data_i[THR_W-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready_o = !fifo_full;
  assign push            = s_axis_tvalid_i && !fifo_full;

  rhcc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .push_i  (push),
    .red_i   (s_axis_tdata_i[15:0]),
    .green_i (s_axis_tdata_i[31:16]),
    .blue_i  (s_axis_tdata_i[47:32]),
    .clear_i (s_axis_tdata_i[63:48]),
    .kind_o  (front_kind),
    .num_o   (front_num),
    .div_o   (front_div)
  );

  assign push_entry = {front_kind, front_num, front_div};

  rhcc_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  rhcc_back #(
    .HUE_BITS    (HUE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avail_i     (!fifo_empty),
    .kind_i      (kind_e'(head_entry[ENTRY_W-1 -: 2])),
    .num_i       (head_entry[2*D6_W-1 -: D6_W]),
    .div_i       (head_entry[D6_W-1:0]),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .color_o     (color),
    .hue_o       (hue)
  );

  assign m_axis_tdata_o = {3'b000, hue, color};

  `RHCC_ASSERT(a_fifo_state_sane, !(fifo_full && fifo_empty), "queue reports full and empty")
  `RHCC_ASSERT(a_pop_has_entry, pop |-> !fifo_empty, "divider took an entry from an empty queue")
  `RHCC_ASSERT(a_result_from_work, $rose(m_axis_tvalid_o) |-> $past(back_busy), "result appeared without divider work")

endmodule
